FILE: sv/tcf_pkg.sv
// Shared types, register codes and constants for the tilt complementary filter.
`default_nettype none
package tcf_pkg;

    // One sample item as it arrives on the input channel.
    typedef struct packed {
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [19:0]        elapsed_us;
    } t_sample_in;

    // One filtered result item.
    typedef struct packed {
        logic signed [15:0] pitch_out;
        logic signed [15:0] roll_out;
    } t_tilt_out;

    // Configuration registers as seen by the lanes.
    typedef struct packed {
        logic [23:0] gyro_scale;
        logic [14:0] max_angle;
        logic [16:0] gyro_weight;
    } t_tcf_cfg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_GYRO_SCALE  = 2'd0;
    localparam logic [1:0] CFG_MAX_ANGLE   = 2'd1;
    localparam logic [1:0] CFG_GYRO_WEIGHT = 2'd2;

    // Reset values of the registers.
    localparam logic [23:0] GYRO_SCALE_RST  = 24'd16777;
    localparam logic [14:0] MAX_ANGLE_RST   = 15'd2560;
    localparam logic [16:0] GYRO_WEIGHT_RST = 17'd64225;

    // Elapsed time limits in microseconds.
    localparam logic [19:0] DT_LIMIT   = 20'd100000;
    localparam logic [16:0] DT_DEFAULT = 17'd10000;

    // Width of the CORDIC x and y datapath; inputs are scaled to 2^30.
    localparam int TCF_CW = 34;

    // Lane sequencer states.
    typedef enum logic [3:0] {
        LS_IDLE,
        LS_SQRT,
        LS_CINIT,
        LS_CORDIC,
        LS_GMUL1,
        LS_GMUL2,
        LS_GINC,
        LS_BMUL,
        LS_BSUM
    } t_lane_state;

    // Top level control states.
    typedef enum logic [1:0] {
        TS_IDLE,
        TS_RUN,
        TS_HOLD
    } t_top_state;

    // atan(2^-i) in 2^-16 degree, rounded to nearest.
    function automatic logic [21:0] atan_entry(input logic [4:0] idx);
        logic [21:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: sv/tcf_lane.sv
// One angle lane: square root, CORDIC atan2, gyro increment and blend with clamp.
`default_nettype none
module tcf_lane #(
    parameter int SW    = 16,
    parameter int STEPS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  signed [SW-1:0]  i_gyro,
    input  wire  signed [SW-1:0]  i_a,
    input  wire  signed [SW-1:0]  i_b,
    input  wire  signed [SW-1:0]  i_c,
    input  wire         [16:0]    i_dt,
    input  tcf_pkg::t_tcf_cfg     i_cfg,
    output logic                  o_done,
    output logic signed [15:0]    o_angle
);

    localparam int RW  = 2 * SW;
    localparam int P1W = SW + 17;
    localparam int HW  = P1W - 21 + 24;
    localparam int MW  = P1W + 24;
    localparam int QW  = MW - 32;
    localparam int IW  = SW + 11;
    localparam int PW  = SW + 31;
    localparam int CW  = tcf_pkg::TCF_CW;
    localparam int SH  = 30 - SW;

    tcf_pkg::t_lane_state r_state, n_state;
    logic [4:0]               r_cnt, n_cnt;
    logic                     r_done, n_done;
    logic signed [15:0]       r_angle, n_angle;
    logic [RW-1:0]            r_rem, n_rem, r_res, n_res, r_bit, n_bit;
    logic signed [SW-1:0]     r_a, n_a;
    logic [SW-1:0]            r_gmag, n_gmag;
    logic                     r_gneg, n_gneg;
    logic [16:0]              r_dt, n_dt;
    logic signed [CW-1:0]     r_x, n_x, r_y, n_y;
    logic signed [31:0]       r_z, n_z;
    logic                     r_zero, n_zero;
    logic [P1W-1:0]           r_p1, n_p1;
    logic [44:0]              r_lo, n_lo;
    logic [HW-1:0]            r_hi, n_hi;
    logic signed [IW-1:0]     r_inc, n_inc;
    logic signed [IW+17:0]    r_pw, n_pw;
    logic signed [34:0]       r_pa, n_pa;

    // Scratch values of the datapath.
    logic signed [RW-1:0]  bsq, csq;
    logic [RW-1:0]         trial;
    logic signed [CW-1:0]  xs, ys;
    logic signed [31:0]    tab, zr;
    logic [MW-1:0]         mprod;
    logic [QW:0]           imag;
    logic signed [IW-1:0]  ipos, ssum;
    logic [16:0]           wsat, wcomp;
    logic signed [16:0]    acc;
    logic signed [PW-1:0]  bsum, bval, lim;

    // Sequencer and datapath for one item.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_angle = r_angle;
        n_rem   = r_rem;
        n_res   = r_res;
        n_bit   = r_bit;
        n_a     = r_a;
        n_gmag  = r_gmag;
        n_gneg  = r_gneg;
        n_dt    = r_dt;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_zero  = r_zero;
        n_p1    = r_p1;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_inc   = r_inc;
        n_pw    = r_pw;
        n_pa    = r_pa;

        bsq   = i_b * i_b;
        csq   = i_c * i_c;
        trial = r_res + r_bit;
        xs    = r_x >>> r_cnt;
        ys    = r_y >>> r_cnt;
        tab   = 32'($signed({1'b0, tcf_pkg::atan_entry(r_cnt)}));
        zr    = r_z + 32'sd128;
        mprod = (MW'(r_hi) << 21) + MW'(r_lo);
        imag  = {1'b0, mprod[MW-1:32]} + (QW+1)'(|mprod[31:0]);
        ipos  = IW'($signed({1'b0, imag}));
        ssum  = IW'(r_angle) + r_inc;
        wsat  = i_cfg.gyro_weight[16] ? 17'h10000 : i_cfg.gyro_weight;
        wcomp = 17'h10000 - wsat;
        acc   = r_zero ? 17'sd0 : 17'(zr >>> 8);
        bsum  = PW'(r_pw) + PW'(r_pa);
        bval  = bsum >>> 16;
        lim   = PW'($signed({1'b0, i_cfg.max_angle}));

        case (r_state)
            tcf_pkg::LS_IDLE: begin
                if (i_start) begin
                    n_rem   = RW'($unsigned(bsq)) + RW'($unsigned(csq));
                    n_res   = '0;
                    n_bit   = RW'(1) << (RW - 2);
                    n_a     = i_a;
                    n_gneg  = i_gyro[SW-1];
                    n_gmag  = i_gyro[SW-1] ? SW'(-i_gyro) : SW'(i_gyro);
                    n_dt    = i_dt;
                    n_cnt   = '0;
                    n_state = tcf_pkg::LS_SQRT;
                end
            end
            // One result bit of the floor square root per cycle.
            tcf_pkg::LS_SQRT: begin
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(SW - 1)) begin
                    n_state = tcf_pkg::LS_CINIT;
                end
            end
            tcf_pkg::LS_CINIT: begin
                n_x     = CW'($signed({1'b0, r_res[SW-1:0]})) <<< SH;
                n_y     = CW'(r_a) <<< SH;
                n_z     = '0;
                n_zero  = (r_res == '0) && (r_a == '0);
                n_cnt   = '0;
                n_state = tcf_pkg::LS_CORDIC;
            end
            // One vectoring rotation per cycle.
            tcf_pkg::LS_CORDIC: begin
                if (!r_y[CW-1]) begin
                    n_x = r_x + ys;
                    n_y = r_y - xs;
                    n_z = r_z + tab;
                end else begin
                    n_x = r_x - ys;
                    n_y = r_y + xs;
                    n_z = r_z - tab;
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(STEPS - 1)) begin
                    n_state = tcf_pkg::LS_GMUL1;
                end
            end
            tcf_pkg::LS_GMUL1: begin
                n_p1    = P1W'(r_gmag) * P1W'(r_dt);
                n_state = tcf_pkg::LS_GMUL2;
            end
            // The rate product is split in two partial products.
            tcf_pkg::LS_GMUL2: begin
                n_lo    = r_p1[20:0] * i_cfg.gyro_scale;
                n_hi    = r_p1[P1W-1:21] * i_cfg.gyro_scale;
                n_state = tcf_pkg::LS_GINC;
            end
            // Floor of the signed product over 2^32.
            tcf_pkg::LS_GINC: begin
                n_inc   = r_gneg ? -ipos : IW'($signed({1'b0, mprod[MW-1:32]}));
                n_state = tcf_pkg::LS_BMUL;
            end
            tcf_pkg::LS_BMUL: begin
                n_pw    = $signed({1'b0, wsat}) * ssum;
                n_pa    = $signed({1'b0, wcomp}) * acc;
                n_state = tcf_pkg::LS_BSUM;
            end
            // Blend and clamp to the angle limit.
            tcf_pkg::LS_BSUM: begin
                if (bval > lim) begin
                    n_angle = 16'(lim);
                end else if (bval < -lim) begin
                    n_angle = 16'(-lim);
                end else begin
                    n_angle = 16'(bval);
                end
                n_done  = 1'b1;
                n_state = tcf_pkg::LS_IDLE;
            end
            default: begin
                n_state = tcf_pkg::LS_IDLE;
            end
        endcase
    end

    // Control state and the stored angle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcf_pkg::LS_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_angle <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            r_angle <= n_angle;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_res  <= n_res;
        r_bit  <= n_bit;
        r_a    <= n_a;
        r_gmag <= n_gmag;
        r_gneg <= n_gneg;
        r_dt   <= n_dt;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_zero <= n_zero;
        r_p1   <= n_p1;
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_inc  <= n_inc;
        r_pw   <= n_pw;
        r_pa   <= n_pa;
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

endmodule
`default_nettype wire

FILE: sv/tilt_complementary_filter.sv
// A new item is taken only while idle, after the previous result has moved to the output register.
// A stalled result holds off the next item. The pitch and roll lanes run side by side.
// Reset (synchronous, active low) clears both angles to zero and loads register defaults.
// Configuration writes are taken in every cycle.
`default_nettype none
module tilt_complementary_filter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  tcf_pkg::t_sample_in  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tcf_pkg::t_tilt_out   o_out_data,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [23:0]          i_cfg_data
);

    localparam int SW = SAMPLE_WIDTH;

    tcf_pkg::t_top_state r_state, n_state;
    tcf_pkg::t_tcf_cfg   r_cfg;
    logic                r_out_valid, n_out_valid;
    tcf_pkg::t_tilt_out  r_out, n_out;

    logic              accept, pitch_done, roll_done;
    logic              out_free;
    logic [16:0]       dt;
    logic signed [15:0] pitch_angle, roll_angle;
    logic [23:0]       ext_gx, ext_gy, ext_ax, ext_ay, ext_az;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // Samples are read as SAMPLE_WIDTH-bit two's complement values.
    assign ext_gx = {8'h00, i_in_data.gyro_x};
    assign ext_gy = {8'h00, i_in_data.gyro_y};
    assign ext_ax = {8'h00, i_in_data.accel_x};
    assign ext_ay = {8'h00, i_in_data.accel_y};
    assign ext_az = {8'h00, i_in_data.accel_z};

    // A zero or out-of-range elapsed time falls back to the default.
    assign dt = ((i_in_data.elapsed_us == 20'd0) || (i_in_data.elapsed_us > tcf_pkg::DT_LIMIT))
              ? tcf_pkg::DT_DEFAULT : i_in_data.elapsed_us[16:0];

    tcf_lane #(.SW(SW), .STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_gyro  ($signed(ext_gx[SW-1:0])),
        .i_a     ($signed(ext_ax[SW-1:0])),
        .i_b     ($signed(ext_ay[SW-1:0])),
        .i_c     ($signed(ext_az[SW-1:0])),
        .i_dt    (dt),
        .i_cfg   (r_cfg),
        .o_done  (pitch_done),
        .o_angle (pitch_angle)
    );

    tcf_lane #(.SW(SW), .STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_gyro  ($signed(ext_gy[SW-1:0])),
        .i_a     ($signed(ext_ay[SW-1:0])),
        .i_b     ($signed(ext_ax[SW-1:0])),
        .i_c     ($signed(ext_az[SW-1:0])),
        .i_dt    (dt),
        .i_cfg   (r_cfg),
        .o_done  (roll_done),
        .o_angle (roll_angle)
    );

    // Control: start both lanes, then merge their angles into the output register.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        case (r_state)
            tcf_pkg::TS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = tcf_pkg::TS_RUN;
                end
            end
            tcf_pkg::TS_RUN: begin
                if (pitch_done && roll_done) begin
                    n_state = tcf_pkg::TS_HOLD;
                end
            end
            tcf_pkg::TS_HOLD: begin
                if (out_free) begin
                    n_out.pitch_out = pitch_angle;
                    n_out.roll_out  = roll_angle;
                    n_out_valid     = 1'b1;
                    n_state         = tcf_pkg::TS_IDLE;
                end
            end
            default: begin
                n_state = tcf_pkg::TS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcf_pkg::TS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // Configuration registers; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gyro_scale  <= tcf_pkg::GYRO_SCALE_RST;
            r_cfg.max_angle   <= tcf_pkg::MAX_ANGLE_RST;
            r_cfg.gyro_weight <= tcf_pkg::GYRO_WEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcf_pkg::CFG_GYRO_SCALE:  r_cfg.gyro_scale  <= i_cfg_data;
                tcf_pkg::CFG_MAX_ANGLE:   r_cfg.max_angle   <= i_cfg_data[14:0];
                tcf_pkg::CFG_GYRO_WEIGHT: r_cfg.gyro_weight <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

FILE: tb/sv/tb_tilt_complementary_filter.sv
// Self-checking testbench for the tilt complementary filter with random idling.
`timescale 1ns / 1ps
module tb_tilt_complementary_filter;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    tcf_pkg::t_sample_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    tcf_pkg::t_tilt_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = tcf_pkg::CFG_GYRO_SCALE;
    logic [23:0] i_cfg_data = '0;

    tilt_complementary_filter dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Predictor copy of registers and filter state.
    logic [23:0] scale_q = tcf_pkg::GYRO_SCALE_RST;
    logic [14:0] limit_q = tcf_pkg::MAX_ANGLE_RST;
    logic [16:0] weight_q = tcf_pkg::GYRO_WEIGHT_RST;
    logic signed [15:0] pitch_q = '0;
    logic signed [15:0] roll_q = '0;

    tcf_pkg::t_tilt_out angles_due[$];
    int errors = 0;
    int samples_sent = 0;
    int angles_seen = 0;
    bit sink_noidle = 1'b0;
    bit src_noidle = 1'b0;
    int sink_hold = 0;
    int hold_req = 0;
    int hold_done = 0;

    // Floor division by 2^s for signed 64-bit values.
    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint int_sqrt(longint unsigned n);
        longint unsigned res = 0, bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    // Accelerometer tilt in 1/256 degree: atan2(a, sqrt(b^2 + c^2)) by CORDIC.
    function automatic longint accel_tilt(longint a, longint b, longint c);
        longint x, y, z, xs, ys;
        x = int_sqrt(longint'(b * b + c * c)) * 16384;
        y = a * 16384;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < 16; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(tcf_pkg::atan_entry(i[4:0]));
            end else begin
                x -= ys; y += xs; z -= longint'(tcf_pkg::atan_entry(i[4:0]));
            end
        end
        return floor_shr(z + 128, 8);
    endfunction

    function automatic longint rate_step(longint raw, longint dt);
        longint unsigned mag, q;
        mag = longint'(raw < 0 ? -raw : raw) * longint'(scale_q) * dt;
        q = mag >> 32;
        if (raw >= 0) return longint'(q);
        if (mag[31:0] != 0) q += 1;
        return -longint'(q);
    endfunction

    function automatic logic signed [15:0] blend_angle(longint old, longint inc, longint acc);
        longint w, v, lim;
        w = (weight_q > 17'd65536) ? 65536 : longint'(weight_q);
        lim = longint'(limit_q);
        v = floor_shr(w * (old + inc) + (65536 - w) * acc, 16);
        if (v > lim) v = lim;
        if (v < -lim) v = -lim;
        return v[15:0];
    endfunction

    // Update the predicted angles for one sample and queue the result.
    task automatic predict_angles(tcf_pkg::t_sample_in s);
        longint dt;
        tcf_pkg::t_tilt_out r;
        dt = longint'(s.elapsed_us);
        if (dt == 0 || dt > 100000) dt = 10000;
        pitch_q = blend_angle(pitch_q, rate_step(s.gyro_x, dt),
                              accel_tilt(s.accel_x, s.accel_y, s.accel_z));
        roll_q = blend_angle(roll_q, rate_step(s.gyro_y, dt),
                             accel_tilt(s.accel_y, s.accel_x, s.accel_z));
        r.pitch_out = pitch_q;
        r.roll_out = roll_q;
        angles_due.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("ERROR at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Send one sample, with an optional random gap first. Valid stays high after the
    // handshake so that a following item can go back to back; idling drops it.
    task automatic send_sample(tcf_pkg::t_sample_in s);
        if (!src_noidle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (!o_in_ready);
        predict_angles(s);
        samples_sent++;
    endtask

    // Write one register, then leave the channel quiet before returning.
    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tcf_pkg::CFG_GYRO_SCALE:  scale_q = val;
            tcf_pkg::CFG_MAX_ANGLE:   limit_q = val[14:0];
            tcf_pkg::CFG_GYRO_WEIGHT: weight_q = val[16:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Stop offering items and wait until every expected result has come.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic tcf_pkg::t_sample_in rand_sample();
        tcf_pkg::t_sample_in s;
        s.gyro_x = 16'($urandom);
        s.gyro_y = 16'($urandom);
        s.accel_x = 16'($urandom);
        s.accel_y = 16'($urandom);
        s.accel_z = 16'($urandom);
        case ($urandom_range(0, 5))
            0: s.elapsed_us = 20'($urandom);
            1: s.elapsed_us = 20'($urandom_range(0, 3));
            default: s.elapsed_us = 20'($urandom_range(1000, 20000));
        endcase
        // Sometimes keep the accelerations small to stress the near-zero vectors.
        if ($urandom_range(0, 7) == 0) begin
            s.accel_x = 16'($signed($urandom_range(0, 4)) - 2);
            s.accel_y = 16'($signed($urandom_range(0, 4)) - 2);
            s.accel_z = 16'($signed($urandom_range(0, 4)) - 2);
        end
        return s;
    endfunction

    // Result sink with random stalls; a long hold is counted here on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done <= hold_req;
            sink_hold <= 400;
            i_out_ready <= 1'b0;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!sink_noidle && $urandom_range(0, 9) == 0) begin
            sink_hold <= $urandom_range(0, 17);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        tcf_pkg::t_tilt_out w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            angles_seen++;
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected result, pitch_out", o_out_data.pitch_out, 0);
            end else begin
                w = angles_due.pop_front();
                if (o_out_data.pitch_out !== w.pitch_out)
                    report_mismatch("pitch_out", o_out_data.pitch_out, w.pitch_out);
                if (o_out_data.roll_out !== w.roll_out)
                    report_mismatch("roll_out", o_out_data.roll_out, w.roll_out);
            end
        end
    end

    task automatic test_field_extremes();
        tcf_pkg::t_sample_in s;
        logic [15:0] ext[4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        logic [19:0] dts[5] = '{20'd0, 20'd100000, 20'd100001, 20'hFFFFF, 20'd1};
        for (int i = 0; i < 16; i++) begin
            s.gyro_x = ext[i % 4];
            s.gyro_y = ext[(i + 1) % 4];
            s.accel_x = ext[(i / 4) % 4];
            s.accel_y = ext[(i + 2) % 4];
            s.accel_z = ext[(i + 3) % 4];
            s.elapsed_us = dts[i % 5];
            send_sample(s);
        end
        // Zero vector for both tilts.
        s = '0;
        s.elapsed_us = 20'd5000;
        send_sample(s);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        logic [23:0] sc[3] = '{24'd0, 24'hFFFFFF, 24'd16777};
        logic [14:0] ma[3] = '{15'd0, 15'd23040, 15'h7FFF};
        logic [16:0] wt[4] = '{17'd0, 17'd65536, 17'h1FFFF, 17'd32768};
        for (int p = 0; p < 4; p++) begin
            write_reg(tcf_pkg::CFG_GYRO_SCALE, sc[p % 3]);
            write_reg(tcf_pkg::CFG_MAX_ANGLE, 24'(ma[p % 3]));
            write_reg(tcf_pkg::CFG_GYRO_WEIGHT, 24'(wt[p]));
            repeat (60) send_sample(rand_sample());
            wait_drained();
        end
        write_reg(tcf_pkg::CFG_GYRO_SCALE, tcf_pkg::GYRO_SCALE_RST);
        write_reg(tcf_pkg::CFG_MAX_ANGLE, 24'd23040);
        write_reg(tcf_pkg::CFG_GYRO_WEIGHT, 24'(tcf_pkg::GYRO_WEIGHT_RST));
    endtask

    task automatic test_backpressure();
        hold_req++;
        repeat (20) send_sample(rand_sample());
        wait_drained();
    endtask

    task automatic test_random_samples();
        for (int i = 0; i < 680; i++) begin
            if (i % 170 == 169) begin
                write_reg(tcf_pkg::CFG_GYRO_WEIGHT, 24'($urandom_range(0, 131071)));
                write_reg(tcf_pkg::CFG_GYRO_SCALE, 24'($urandom));
                write_reg(tcf_pkg::CFG_MAX_ANGLE, 24'($urandom_range(0, 23040)));
            end
            send_sample(rand_sample());
            if (i % 170 == 168) wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_no_idling();
        src_noidle = 1'b1;
        sink_noidle = 1'b1;
        repeat (60) send_sample(rand_sample());
        wait_drained();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_extremes();
        test_register_extremes();
        test_backpressure();
        test_random_samples();
        test_no_idling();
        $display("Sent %0d samples, checked %0d results across extreme and random settings.",
                 samples_sent, angles_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", angles_due.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
